// ===== hw/rtl/gfalu_pkg.sv =====
// Shared types, constants and helper functions for the GF(2^m) arithmetic unit.
// Depends on nothing; every other file of the unit imports it.
package gfalu_pkg;

   // Element width, degree register width and bit-index width
   localparam int ELEM_W = 64;
   localparam int DEG_W = 7;
   localparam int IDX_W = 6;

   // Degree limits and reset values of the configuration registers
   localparam int MIN_DEGREE = 2;
   localparam int DEF_MAX_DEGREE = 64;
   localparam logic [DEG_W-1:0] RESET_DEGREE = 7'd8;
   localparam logic [ELEM_W-1:0] RESET_POLY = 64'd27;

   // Multiply steps done by one pipeline stage
   localparam int BITS_PER_STAGE = 8;

   // Request and response bus widths
   localparam int FUNC_W = 2;
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 64;

   // Configuration register indexes
   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FIELD_DEGREE = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_REDUCTION_POLY = 1'b1;

   // Operation codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD = 2'd0,
      FUNC_MUL = 2'd1,
      FUNC_MULX = 2'd2,
      FUNC_DIVX = 2'd3
   } func_type;

   // Running state of one multiplication as it moves down the pipeline
   typedef struct packed {
      logic [ELEM_W-1:0] acc;
      logic [ELEM_W-1:0] d;
      logic [ELEM_W-1:0] b;
   } mul_state_type;

   // Field parameters derived from the configuration registers
   typedef struct packed {
      logic [IDX_W-1:0] m_top;
      logic [ELEM_W-1:0] mask;
      logic [ELEM_W-1:0] poly;
   } field_cfg_type;

   // Mask of the m low bits, for 1 <= m <= ELEM_W
   function automatic logic [ELEM_W-1:0] deg_mask(input logic [DEG_W-1:0] m);
      logic [ELEM_W-1:0] ones;
      ones = '1;
      return ones >> (DEG_W'(ELEM_W) - m);
   endfunction

   // Multiply by x with reduction
   function automatic logic [ELEM_W-1:0] times_x(input logic [ELEM_W-1:0] v,
                                                 input field_cfg_type cfg);
      logic top;
      logic [ELEM_W-1:0] r;
      top = v[cfg.m_top];
      r = (v << 1) & cfg.mask;
      if (top) begin
         r = r ^ cfg.poly;
      end
      return r;
   endfunction

   // Divide by x: shift right and fold the dropped bit back through the polynomial
   function automatic logic [ELEM_W-1:0] div_x(input logic [ELEM_W-1:0] v,
                                               input field_cfg_type cfg);
      logic [ELEM_W-1:0] r;
      logic [ELEM_W-1:0] top_bit;
      r = v >> 1;
      top_bit = '0;
      top_bit[cfg.m_top] = 1'b1;
      if (v[0]) begin
         r = (r | top_bit) ^ (cfg.poly >> 1);
      end
      return r & cfg.mask;
   endfunction

endpackage

// ===== hw/rtl/gfalu_front.sv =====
// Entry stage of the GF(2^m) unit: masks operands, performs add, multiply by x
// and divide by x, and sets up the multiply state. Depends on gfalu_pkg.
module gfalu_front
   import gfalu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  field_cfg_type cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  func_type      in_func,
   input  logic [ELEM_W-1:0] in_a,
   input  logic [ELEM_W-1:0] in_b,
   output logic          out_valid,
   input  logic          out_ready,
   output mul_state_type out_state
);

   logic          valid_ff;
   mul_state_type state_ff;
   mul_state_type state_in;
   logic [ELEM_W-1:0] a_m;
   logic [ELEM_W-1:0] b_m;

   // Decode the operation; only a multiply leaves work for the later stages
   always_comb begin
      a_m = in_a & cfg.mask;
      b_m = in_b & cfg.mask;
      state_in = '0;
      case (in_func)
         FUNC_ADD: begin
            state_in.acc = a_m ^ b_m;
         end
         FUNC_MUL: begin
            state_in.d = a_m;
            state_in.b = b_m;
         end
         FUNC_MULX: begin
            state_in.acc = times_x(a_m, cfg);
         end
         FUNC_DIVX: begin
            state_in.acc = div_x(a_m, cfg);
         end
         default: begin
            state_in = '0;
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

// ===== hw/rtl/gfalu_mul_stage.sv =====
// One multiply stage of the GF(2^m) unit: handles BITS_PER_STAGE bits of the
// second operand, LSB first. Depends on gfalu_pkg.
module gfalu_mul_stage
   import gfalu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  field_cfg_type cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  mul_state_type in_state,
   output logic          out_valid,
   input  logic          out_ready,
   output mul_state_type out_state
);

   logic          valid_ff;
   mul_state_type state_ff;
   mul_state_type state_in;
   logic [ELEM_W-1:0] acc;
   logic [ELEM_W-1:0] d;

   // Shift-and-add steps: add the running multiple where b has a one, then times x
   always_comb begin
      acc = in_state.acc;
      d = in_state.d;
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
         if (in_state.b[j]) begin
            acc = acc ^ d;
         end
         d = times_x(d, cfg);
      end
      state_in.acc = acc;
      state_in.d = d;
      state_in.b = in_state.b >> BITS_PER_STAGE;
   end

   assign in_ready = !valid_ff || out_ready;

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

// ===== hw/rtl/gf2m_polynomial_basis_alu.sv =====
// GF(2^m) polynomial-basis arithmetic unit, top level: configuration registers
// and the pipeline. Depends on gfalu_pkg, gfalu_front and gfalu_mul_stage.
//
// Each request carries an operation (add, multiply, multiply by x, divide by x)
// and two operands and gives one response with the reduced field element. The
// unit takes a new request every cycle unless a stalled response backs up the
// pipeline. A request passes the entry stage and then the multiply stages, eight
// shift-and-add steps per stage. The last stage is the response register, and a
// stall holds every occupied stage while empty stages keep filling. Bits at or
// above m in operands and polynomial are ignored; the degree is the low 7 bits of
// the write data, a degree below 2 acts as 2 and one above MAX_DEGREE acts as
// MAX_DEGREE. Write the configuration only while no request is in flight.
module gf2m_polynomial_basis_alu
   import gfalu_pkg::*;
#(
   parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request: func [1:0], operand_a [65:2], operand_b [129:66], zeros above
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Response: result [63:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // Configuration write port
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [ELEM_W-1:0]     csr_wdata
);

   localparam int NUM_STAGES = (MAX_DEGREE + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

   // Configuration registers with derived mask and reduced polynomial
   logic [ELEM_W-1:0] poly_raw_ff;
   field_cfg_type     cfg_ff;
   logic [DEG_W-1:0]  deg_in;
   logic [ELEM_W-1:0] mask_in;

   always_comb begin
      deg_in = csr_wdata[DEG_W-1:0];
      if (deg_in < DEG_W'(MIN_DEGREE)) begin
         deg_in = DEG_W'(MIN_DEGREE);
      end else if (deg_in > DEG_W'(MAX_DEGREE)) begin
         deg_in = DEG_W'(MAX_DEGREE);
      end
      mask_in = deg_mask(deg_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_raw_ff <= RESET_POLY;
         cfg_ff.m_top <= IDX_W'(RESET_DEGREE - 1'b1);
         cfg_ff.mask <= deg_mask(RESET_DEGREE);
         cfg_ff.poly <= RESET_POLY & deg_mask(RESET_DEGREE);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FIELD_DEGREE: begin
               cfg_ff.m_top <= IDX_W'(deg_in - 1'b1);
               cfg_ff.mask <= mask_in;
               cfg_ff.poly <= poly_raw_ff & mask_in;
            end
            CSR_REDUCTION_POLY: begin
               poly_raw_ff <= csr_wdata;
               cfg_ff.poly <= csr_wdata & cfg_ff.mask;
            end
            default: begin
               poly_raw_ff <= poly_raw_ff;
            end
         endcase
      end
   end

   // Pipeline links: index 0 is the entry stage output, NUM_STAGES the last
   logic          link_valid [NUM_STAGES+1];
   logic          link_ready [NUM_STAGES+1];
   mul_state_type link_state [NUM_STAGES+1];

   gfalu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_func   (func_type'(req_tdata[FUNC_W-1:0])),
      .in_a      (req_tdata[FUNC_W +: ELEM_W]),
      .in_b      (req_tdata[FUNC_W+ELEM_W +: ELEM_W]),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_state (link_state[0])
   );

   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
      gfalu_mul_stage u_mul (
         .clock     (clock),
         .reset     (reset),
         .cfg       (cfg_ff),
         .in_valid  (link_valid[k]),
         .in_ready  (link_ready[k]),
         .in_state  (link_state[k]),
         .out_valid (link_valid[k+1]),
         .out_ready (link_ready[k+1]),
         .out_state (link_state[k+1])
      );
   end

   // The last stage register drives the response
   assign link_ready[NUM_STAGES] = rsp_tready;
   assign rsp_tvalid = link_valid[NUM_STAGES];
   assign rsp_tdata = link_state[NUM_STAGES].acc;

endmodule

// ===== hw/rtl/gfalu_checker.sv =====
// Port-level assertions for the GF(2^m) unit, bound to the top level.
// Depends on gfalu_pkg for bus widths.
module gfalu_checker
   import gfalu_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Reset empties the pipeline, so no response shows in the next cycle.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // When the output moves or is empty, every stage can move, so a request is taken.
   a_no_bubble_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("request refused while the pipeline can advance");

   // A request is never refused while the response register is empty.
   a_accept_free: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !rsp_tvalid |-> req_tready)
      else $error("request refused with the response register empty");

endmodule

bind gf2m_polynomial_basis_alu gfalu_checker u_checker (.*);
